FILE: sv/nearest_timestamp_stereo_imu_sync_top_assert.svh
// Assertion macros for the stereo IMU sync block; empty under synthesis.
`ifndef NEAREST_TIMESTAMP_STEREO_IMU_SYNC_TOP_ASSERT_SVH
`define NEAREST_TIMESTAMP_STEREO_IMU_SYNC_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NTS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nts same-cycle check failed");
// next-cycle implication
`define NTS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nts next-cycle check failed");
`else
`define NTS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NTS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: sv/nts_pkg.sv
// Shared types, constants and slot helpers for the stereo IMU sync block.
`default_nettype none

package nts_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_AW      = QIDX_W + 1;
   localparam int MEM_DEPTH   = 2 ** MEM_AW;

   // field widths
   localparam int STAMP_W = 48;
   localparam int TAG_W   = 32;
   localparam int CSR_W   = 32;
   localparam int ENTRY_W = STAMP_W + TAG_W;

   // item modes
   localparam logic [1:0] MODE_IMU   = 2'd0;
   localparam logic [1:0] MODE_LEFT  = 2'd1;
   localparam logic [1:0] MODE_RIGHT = 2'd2;

   // register indexes
   localparam logic CSR_MAX_OFFSET = 1'b0;
   localparam logic CSR_MAX_AGE    = 1'b1;

   // register reset values
   localparam logic [CSR_W-1:0] MAX_OFFSET_RST = CSR_W'(10000);
   localparam logic [CSR_W-1:0] MAX_AGE_RST    = CSR_W'(1000000);

   // queue sides
   localparam logic SIDE_LEFT  = 1'b0;
   localparam logic SIDE_RIGHT = 1'b1;

   typedef struct packed {
      logic [1:0]         mode;
      logic [STAMP_W-1:0] stamp;
      logic [TAG_W-1:0]   tag;
   } req_type;

   typedef struct packed {
      logic [STAMP_W-1:0] imu_stamp;
      logic [TAG_W-1:0]   imu_tag;
      logic               both_found;
      logic [TAG_W-1:0]   left_tag;
      logic [STAMP_W-1:0] left_stamp;
      logic [TAG_W-1:0]   right_tag;
      logic [STAMP_W-1:0] right_stamp;
   } rsp_type;

   // slot after s, wrapping at the queue depth
   function automatic logic [QIDX_W-1:0] next_slot(input logic [QIDX_W-1:0] s);
      if (s == QIDX_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return s + QIDX_W'(1);
   endfunction

   // slot of entry cnt counted from head, wrapping at the queue depth
   function automatic logic [QIDX_W-1:0] tail_slot(input logic [QIDX_W-1:0] head,
                                                   input logic [CNT_W-1:0]  cnt);
      logic [QIDX_W:0] sum;
      sum = {1'b0, head} + (QIDX_W+1)'(cnt);
      if (sum >= (QIDX_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (QIDX_W+1)'(QUEUE_DEPTH);
      end
      return sum[QIDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: sv/nearest_timestamp_stereo_imu_sync_top.sv
// Stereo frame to IMU nearest-timestamp synchronizer: top level.
//
// Usage: frames (mode left or right) and IMU samples (mode IMU) enter on the
// req_ channel (valid/ready). A frame item is written into its side's queue
// in the accept cycle and gives no result; a full queue drops its oldest
// frame. An IMU item scans the left queue for the nearest frame, prunes stale
// frames from its oldest end, then does the same on the right, and puts one
// item on the rsp_ channel. A mode 3 item is taken and dropped.
// An IMU item walks each queue through the single read port of the shared
// frame memory and the one gap/compare unit, with a read state and a compare
// state for every scanned entry and every pruned entry.
// req_ready is high only while the sequencer is idle; the result sits in an
// output register, so the next item may be taken while it waits. If the
// receiver stalls and a second result is ready, the sequencer holds it until
// the output register frees.
// Reset (synchronous, active high) empties both queues, clears rsp_valid
// and loads the register defaults. csr_ writes take effect at once.
`default_nettype none

`include "nearest_timestamp_stereo_imu_sync_top_assert.svh"

module nearest_timestamp_stereo_imu_sync_top
   import nts_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // input items
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire req_type          req_data,
   // result items
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      rsp_type          rsp_data,
   // register writes
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_PRUNE_RD,
      ST_PRUNE_CMP,
      ST_DONE
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic               side_ff, side_in;
   logic [QIDX_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic               have_ff, have_in;
   logic [QIDX_W-1:0]  l_head_ff, l_head_in, r_head_ff, r_head_in;
   logic [CNT_W-1:0]   l_cnt_ff, l_cnt_in, r_cnt_ff, r_cnt_in;
   logic               l_ok_ff, l_ok_in, r_ok_ff, r_ok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CSR_W-1:0]   offset_ff, offset_in, age_ff, age_in;

   // payload state
   logic [STAMP_W-1:0] best_ff, best_in;
   logic [STAMP_W-1:0] imu_stamp_ff, imu_stamp_in;
   logic [TAG_W-1:0]   imu_tag_ff, imu_tag_in;
   logic [STAMP_W-1:0] l_stamp_ff, l_stamp_in, r_stamp_ff, r_stamp_in;
   logic [TAG_W-1:0]   l_tag_ff, l_tag_in, r_tag_ff, r_tag_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // frame memory: both queues, side bit on top of the address
   logic [ENTRY_W-1:0] mem [MEM_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [MEM_AW-1:0]  rd_addr;
   logic [MEM_AW-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               wr_en;

   // shared gap unit
   logic [STAMP_W-1:0] ent_stamp;
   logic [TAG_W-1:0]   ent_tag;
   logic [STAMP_W:0]   diff_up;
   logic               frame_newer;
   logic [STAMP_W-1:0] gap;
   logic               closer;
   logic               stale;
   logic               in_offset;

   // current side views
   logic [QIDX_W-1:0]  cur_head;
   logic [CNT_W-1:0]   cur_cnt;
   logic               l_full, r_full;

   // check terms
   logic               chk_cnt_ok;
   logic               chk_head_ok;
   logic               chk_imu_take;
   logic               chk_rsp_zero;

   assign cur_head = side_ff ? r_head_ff : l_head_ff;
   assign cur_cnt  = side_ff ? r_cnt_ff  : l_cnt_ff;
   assign l_full   = (l_cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign r_full   = (r_cnt_ff == CNT_W'(QUEUE_DEPTH));

   assign ent_stamp   = rd_data_ff[ENTRY_W-1 -: STAMP_W];
   assign ent_tag     = rd_data_ff[TAG_W-1:0];
   assign diff_up     = {1'b0, imu_stamp_ff} - {1'b0, ent_stamp};
   assign frame_newer = diff_up[STAMP_W];
   assign gap         = frame_newer ? (ent_stamp - imu_stamp_ff) : diff_up[STAMP_W-1:0];
   assign closer      = !have_ff || (gap < best_ff);
   assign stale       = !frame_newer && (gap > STAMP_W'(age_ff));
   assign in_offset   = have_ff && (best_ff <= STAMP_W'(offset_ff));

   assign rd_addr = {side_ff, (state_ff == ST_PRUNE_RD) ? cur_head : ptr_ff};

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // frame memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      ptr_in       = ptr_ff;
      k_in         = k_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      l_head_in    = l_head_ff;
      r_head_in    = r_head_ff;
      l_cnt_in     = l_cnt_ff;
      r_cnt_in     = r_cnt_ff;
      l_ok_in      = l_ok_ff;
      r_ok_in      = r_ok_ff;
      l_stamp_in   = l_stamp_ff;
      r_stamp_in   = r_stamp_ff;
      l_tag_in     = l_tag_ff;
      r_tag_in     = r_tag_ff;
      imu_stamp_in = imu_stamp_ff;
      imu_tag_in   = imu_tag_ff;
      offset_in    = offset_ff;
      age_in       = age_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = {req_data.stamp, req_data.tag};

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_OFFSET: offset_in = csr_wdata;
            CSR_MAX_AGE:    age_in    = csr_wdata;
            default:        ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.mode)
                  MODE_LEFT: begin
                     wr_en   = 1'b1;
                     wr_addr = {SIDE_LEFT, l_full ? l_head_ff : tail_slot(l_head_ff, l_cnt_ff)};
                     if (l_full) begin
                        l_head_in = next_slot(l_head_ff);
                     end else begin
                        l_cnt_in = l_cnt_ff + CNT_W'(1);
                     end
                  end
                  MODE_RIGHT: begin
                     wr_en   = 1'b1;
                     wr_addr = {SIDE_RIGHT, r_full ? r_head_ff : tail_slot(r_head_ff, r_cnt_ff)};
                     if (r_full) begin
                        r_head_in = next_slot(r_head_ff);
                     end else begin
                        r_cnt_in = r_cnt_ff + CNT_W'(1);
                     end
                  end
                  MODE_IMU: begin
                     imu_stamp_in = req_data.stamp;
                     imu_tag_in   = req_data.tag;
                     side_in      = SIDE_LEFT;
                     ptr_in       = l_head_ff;
                     k_in         = '0;
                     have_in      = 1'b0;
                     state_in     = ST_SCAN_RD;
                  end
                  default: ;
               endcase
            end
         end

         // read entry k, or close the scan of this side
         ST_SCAN_RD: begin
            if (k_ff == cur_cnt) begin
               if (side_ff == SIDE_RIGHT) begin
                  r_ok_in = in_offset;
               end else begin
                  l_ok_in = in_offset;
               end
               state_in = ST_PRUNE_RD;
            end else begin
               state_in = ST_SCAN_CMP;
            end
         end

         // keep the nearest entry; strict compare keeps the oldest on a tie
         ST_SCAN_CMP: begin
            if (closer) begin
               have_in = 1'b1;
               best_in = gap;
               if (side_ff == SIDE_RIGHT) begin
                  r_stamp_in = ent_stamp;
                  r_tag_in   = ent_tag;
               end else begin
                  l_stamp_in = ent_stamp;
                  l_tag_in   = ent_tag;
               end
            end
            ptr_in   = next_slot(ptr_ff);
            k_in     = k_ff + CNT_W'(1);
            state_in = ST_SCAN_RD;
         end

         // read the oldest entry, or move on when the side is empty
         ST_PRUNE_RD: begin
            if (cur_cnt == '0) begin
               if (side_ff == SIDE_RIGHT) begin
                  state_in = ST_DONE;
               end else begin
                  side_in  = SIDE_RIGHT;
                  ptr_in   = r_head_ff;
                  k_in     = '0;
                  have_in  = 1'b0;
                  state_in = ST_SCAN_RD;
               end
            end else begin
               state_in = ST_PRUNE_CMP;
            end
         end

         // drop a stale oldest entry; stop at the first fresh one
         ST_PRUNE_CMP: begin
            if (stale) begin
               if (side_ff == SIDE_RIGHT) begin
                  r_head_in = next_slot(r_head_ff);
                  r_cnt_in  = r_cnt_ff - CNT_W'(1);
               end else begin
                  l_head_in = next_slot(l_head_ff);
                  l_cnt_in  = l_cnt_ff - CNT_W'(1);
               end
               state_in = ST_PRUNE_RD;
            end else if (side_ff == SIDE_RIGHT) begin
               state_in = ST_DONE;
            end else begin
               side_in  = SIDE_RIGHT;
               ptr_in   = r_head_ff;
               k_in     = '0;
               have_in  = 1'b0;
               state_in = ST_SCAN_RD;
            end
         end

         // load the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.imu_stamp  = imu_stamp_ff;
               rsp_data_in.imu_tag    = imu_tag_ff;
               rsp_data_in.both_found = l_ok_ff && r_ok_ff;
               rsp_data_in.left_tag   = (l_ok_ff && r_ok_ff) ? l_tag_ff   : '0;
               rsp_data_in.left_stamp = (l_ok_ff && r_ok_ff) ? l_stamp_ff : '0;
               rsp_data_in.right_tag  = (l_ok_ff && r_ok_ff) ? r_tag_ff   : '0;
               rsp_data_in.right_stamp = (l_ok_ff && r_ok_ff) ? r_stamp_ff : '0;
               state_in               = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= SIDE_LEFT;
         ptr_ff       <= '0;
         k_ff         <= '0;
         have_ff      <= 1'b0;
         l_head_ff    <= '0;
         r_head_ff    <= '0;
         l_cnt_ff     <= '0;
         r_cnt_ff     <= '0;
         l_ok_ff      <= 1'b0;
         r_ok_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         offset_ff    <= MAX_OFFSET_RST;
         age_ff       <= MAX_AGE_RST;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         ptr_ff       <= ptr_in;
         k_ff         <= k_in;
         have_ff      <= have_in;
         l_head_ff    <= l_head_in;
         r_head_ff    <= r_head_in;
         l_cnt_ff     <= l_cnt_in;
         r_cnt_ff     <= r_cnt_in;
         l_ok_ff      <= l_ok_in;
         r_ok_ff      <= r_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         offset_ff    <= offset_in;
         age_ff       <= age_in;
      end
      best_ff      <= best_in;
      imu_stamp_ff <= imu_stamp_in;
      imu_tag_ff   <= imu_tag_in;
      l_stamp_ff   <= l_stamp_in;
      r_stamp_ff   <= r_stamp_in;
      l_tag_ff     <= l_tag_in;
      r_tag_ff     <= r_tag_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // check terms
   assign chk_cnt_ok   = (l_cnt_ff <= CNT_W'(QUEUE_DEPTH)) && (r_cnt_ff <= CNT_W'(QUEUE_DEPTH));
   assign chk_head_ok  = (l_head_ff < QIDX_W'(QUEUE_DEPTH - 1)) ||
                         (l_head_ff == QIDX_W'(QUEUE_DEPTH - 1));
   assign chk_imu_take = req_valid && req_ready && (req_data.mode == MODE_IMU);
   assign chk_rsp_zero = (rsp_data_ff.left_tag == '0) && (rsp_data_ff.right_tag == '0) &&
                         (rsp_data_ff.left_stamp == '0) && (rsp_data_ff.right_stamp == '0);

   // checks
   `NTS_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, chk_cnt_ok)
   `NTS_ASSERT_IMP(a_head_bound, clock, reset, 1'b1, chk_head_ok)
   `NTS_ASSERT_NXT(a_imu_starts, clock, reset, chk_imu_take, state_ff == ST_SCAN_RD)
   `NTS_ASSERT_IMP(a_partial_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.both_found, chk_rsp_zero)
   `NTS_ASSERT_IMP(a_scan_range, clock, reset, state_ff == ST_SCAN_CMP, k_ff < cur_cnt)

endmodule

`default_nettype wire
